// ----- hw/rtl/tcgl_pkg.sv -----
`default_nettype none

package tcgl_pkg;

	localparam int CODE_W    = 8;
	localparam int COORD_W   = 13;
	localparam int CFG_W     = 12;
	localparam int COL_W     = 4;
	localparam int ROW_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [COORD_W-1:0] COORD_MAX = 13'h1FFF;

	localparam logic [CODE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CODE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CODE_W-1:0] CODE_FIRST = 8'h20;
	localparam logic [CODE_W-1:0] CODE_LAST  = 8'h7F;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_X     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_Y     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

	localparam logic [CFG_W-1:0] BASE_X_RST     = 12'd0;
	localparam logic [CFG_W-1:0] BASE_Y_RST     = 12'd0;
	localparam logic [CFG_W-1:0] BOX_WIDTH_RST  = 12'd300;
	localparam logic [CFG_W-1:0] BOX_HEIGHT_RST = 12'd300;

	typedef struct packed {
		logic [CODE_W-1:0] char_code;
		logic              start_of_text;
	} text_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] base_x;
		logic [CFG_W-1:0] base_y;
		logic [CFG_W-1:0] box_width;
		logic [CFG_W-1:0] box_height;
	} box_cfg_t;

	typedef struct packed {
		logic               emit;
		logic [COORD_W-1:0] glyph_x;
		logic [COORD_W-1:0] glyph_y;
		logic               box_full_after;
	} cursor_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcgl_if.sv -----
`default_nettype none

interface tcgl_in_if;
	import tcgl_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] char_code;
	logic              start_of_text;

	modport source (output valid, char_code, start_of_text, input ready);
	modport sink (input valid, char_code, start_of_text, output ready);
endinterface

interface tcgl_out_if;
	import tcgl_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] glyph_x;
	logic [COORD_W-1:0] glyph_y;
	logic [COL_W-1:0]   glyph_column;
	logic [ROW_W-1:0]   glyph_row;
	logic               box_full_after;

	modport source (output valid, glyph_x, glyph_y, glyph_column, glyph_row, box_full_after,
		input ready);
	modport sink (input valid, glyph_x, glyph_y, glyph_column, glyph_row, box_full_after,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcgl_glyph_map.sv -----
`default_nettype none

module tcgl_glyph_map #(
	parameter int GLYPHS_PER_ROW = 16
) (
	input  wire logic [tcgl_pkg::CODE_W-1:0] char_code,
	output logic      [tcgl_pkg::COL_W-1:0]  glyph_column,
	output logic      [tcgl_pkg::ROW_W-1:0]  glyph_row
);
	import tcgl_pkg::*;

	localparam int NUM_GLYPHS = int'(CODE_LAST) - int'(CODE_FIRST) + 1;
	localparam int IDX_W      = $clog2(NUM_GLYPHS);

	logic [COL_W-1:0] col_tbl [NUM_GLYPHS];
	logic [ROW_W-1:0] row_tbl [NUM_GLYPHS];
	logic [IDX_W-1:0] idx;
	logic [CODE_W-1:0] rel;

	for (genvar g = 0; g < NUM_GLYPHS; g++) begin : g_tbl
		localparam int COL_V = g % GLYPHS_PER_ROW;
		localparam int ROW_V = g / GLYPHS_PER_ROW;
		assign col_tbl[g] = COL_W'(COL_V);
		assign row_tbl[g] = ROW_W'(ROW_V);
	end

	// Control codes and the upper half of the byte range show the blank glyph.
	always_comb begin
		rel = char_code - CODE_FIRST;
		if (char_code >= CODE_FIRST && char_code <= CODE_LAST) begin
			idx = rel[IDX_W-1:0];
		end else begin
			idx = '0;
		end
		glyph_column = col_tbl[idx];
		glyph_row    = row_tbl[idx];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tcgl_cursor.sv -----
`default_nettype none

module tcgl_cursor #(
	parameter int CELL_WIDTH  = 8,
	parameter int CELL_HEIGHT = 16,
	parameter int TAB_CELLS   = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tcgl_pkg::box_cfg_t    cfg,
	input  wire tcgl_pkg::text_item_t  item,
	input  wire logic                  fire,
	output tcgl_pkg::cursor_res_t      res
);
	import tcgl_pkg::*;

	localparam int TAB_SPAN = CELL_WIDTH * TAB_CELLS;
	localparam int TAB_SH   = $clog2(TAB_SPAN);
	localparam int SHIFT    = COORD_W + TAB_SH;
	localparam longint RECIP = ((64'd1 << SHIFT) + longint'(TAB_SPAN) - 1) / TAB_SPAN;
	localparam int RECIP_W  = COORD_W + 2;
	localparam int PROD_W   = COORD_W + RECIP_W;
	localparam int WIDE_W   = COORD_W + 11;

	logic [COORD_W-1:0] cur_x_q, cur_y_q;
	logic               stopped_q;

	logic [COORD_W-1:0] x0, y0, lim_x, lim_y, nl_y, off, quo, tab_x, x1;
	logic               stp0, nl_stop, wrap;
	logic [COORD_W:0]   y_sum, x_sum, x1_next;
	logic [PROD_W-1:0]  prod;
	logic [WIDE_W-1:0]  tab_off, tab_sum;
	logic [COORD_W-1:0] x_n, y_n;
	logic               s_n;

	always_comb begin
		x0    = item.start_of_text ? COORD_W'(cfg.base_x) : cur_x_q;
		y0    = item.start_of_text ? COORD_W'(cfg.base_y) : cur_y_q;
		stp0  = item.start_of_text ? 1'b0 : stopped_q;
		lim_x = COORD_W'(cfg.base_x) + COORD_W'(cfg.box_width);
		lim_y = COORD_W'(cfg.base_y) + COORD_W'(cfg.box_height);

		y_sum   = {1'b0, y0} + (COORD_W+1)'(CELL_HEIGHT);
		nl_y    = y_sum[COORD_W] ? COORD_MAX : y_sum[COORD_W-1:0];
		nl_stop = nl_y > lim_y;

		off     = (x0 >= COORD_W'(cfg.base_x)) ? x0 - COORD_W'(cfg.base_x) : '0;
		prod    = PROD_W'(off) * PROD_W'(RECIP);
		quo     = COORD_W'(prod >> SHIFT);
		tab_off = (WIDE_W'(quo) + WIDE_W'(1)) * WIDE_W'(TAB_SPAN);
		tab_sum = WIDE_W'(cfg.base_x) + tab_off;
		tab_x   = (tab_sum > WIDE_W'(COORD_MAX)) ? COORD_MAX : tab_sum[COORD_W-1:0];

		x_sum   = {1'b0, x0} + (COORD_W+1)'(CELL_WIDTH);
		x1      = x_sum[COORD_W] ? COORD_MAX : x_sum[COORD_W-1:0];
		x1_next = {1'b0, x1} + (COORD_W+1)'(CELL_WIDTH);
		wrap    = x1_next > {1'b0, lim_x};

		x_n = x0;
		y_n = y0;
		s_n = stp0;
		res.emit = 1'b0;
		res.box_full_after = 1'b0;
		if (!stp0) begin
			case (item.char_code)
				CHAR_CR: begin
					x_n = COORD_W'(cfg.base_x);
				end
				CHAR_LF: begin
					x_n = COORD_W'(cfg.base_x);
					y_n = nl_y;
					s_n = nl_stop;
				end
				CHAR_TAB: begin
					x_n = tab_x;
					if (tab_x > lim_x) begin
						x_n = COORD_W'(cfg.base_x);
						y_n = nl_y;
						s_n = nl_stop;
					end
				end
				default: begin
					res.emit = 1'b1;
					x_n = x1;
					if (wrap) begin
						x_n = COORD_W'(cfg.base_x);
						y_n = nl_y;
						s_n = nl_stop;
						res.box_full_after = nl_stop;
					end
				end
			endcase
		end
		res.glyph_x = x0;
		res.glyph_y = y0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			stopped_q <= 1'b0;
		end else if (fire) begin
			cur_x_q   <= x_n;
			cur_y_q   <= y_n;
			stopped_q <= s_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/text_cursor_glyph_layout.sv -----
// A word is held in an input stage register, its result in an output stage register.
// One word per cycle unless output stalls; cursor and glyph logic is combinational.
// A word that gives no result leaves the block at the next edge.
// Reset clears the cursor, the stop flag and all valid bits and loads the
// register reset values; no clearing pass is needed.
`default_nettype none

module text_cursor_glyph_layout #(
	parameter int CELL_WIDTH     = 8,
	parameter int CELL_HEIGHT    = 16,
	parameter int GLYPHS_PER_ROW = 16,
	parameter int TAB_CELLS      = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	tcgl_in_if.sink                                 text_in,
	tcgl_out_if.source                              glyph_out,
	input  wire logic                               cfg_we,
	input  wire logic [tcgl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tcgl_pkg::CFG_W-1:0]         cfg_wdata
);
	import tcgl_pkg::*;

	box_cfg_t    cfg_q;
	text_item_t  item_s1;
	logic        valid_s1;
	cursor_res_t res;
	logic        out_can, fire;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;

	logic               out_valid_q;
	logic [COORD_W-1:0] gx_q, gy_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_x     <= BASE_X_RST;
			cfg_q.base_y     <= BASE_Y_RST;
			cfg_q.box_width  <= BOX_WIDTH_RST;
			cfg_q.box_height <= BOX_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_X:     cfg_q.base_x     <= cfg_wdata;
				REG_BASE_Y:     cfg_q.base_y     <= cfg_wdata;
				REG_BOX_WIDTH:  cfg_q.box_width  <= cfg_wdata;
				REG_BOX_HEIGHT: cfg_q.box_height <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign out_can       = !out_valid_q || glyph_out.ready;
	assign fire          = valid_s1 && (!res.emit || out_can);
	assign text_in.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			item_s1.char_code     <= text_in.char_code;
			item_s1.start_of_text <= text_in.start_of_text;
		end
	end

	tcgl_cursor #(
		.CELL_WIDTH  (CELL_WIDTH),
		.CELL_HEIGHT (CELL_HEIGHT),
		.TAB_CELLS   (TAB_CELLS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.fire   (fire),
		.res    (res)
	);

	tcgl_glyph_map #(
		.GLYPHS_PER_ROW (GLYPHS_PER_ROW)
	) u_glyph_map (
		.char_code    (item_s1.char_code),
		.glyph_column (col),
		.glyph_row    (row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_can) begin
			out_valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_can && valid_s1 && res.emit) begin
			gx_q   <= res.glyph_x;
			gy_q   <= res.glyph_y;
			col_q  <= col;
			row_q  <= row;
			full_q <= res.box_full_after;
		end
	end

	assign glyph_out.valid          = out_valid_q;
	assign glyph_out.glyph_x        = gx_q;
	assign glyph_out.glyph_y        = gy_q;
	assign glyph_out.glyph_column   = col_q;
	assign glyph_out.glyph_row      = row_q;
	assign glyph_out.box_full_after = full_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tcgl_checker.sv -----
`default_nettype none

module tcgl_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [tcgl_pkg::COORD_W-1:0]      glyph_x,
	input wire logic [tcgl_pkg::COORD_W-1:0]      glyph_y,
	input wire logic [tcgl_pkg::COL_W-1:0]        glyph_column,
	input wire logic [tcgl_pkg::ROW_W-1:0]        glyph_row,
	input wire logic                              box_full_after
);
	import tcgl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(glyph_x) && $stable(glyph_y)
			&& $stable(glyph_column) && $stable(glyph_row) && $stable(box_full_after))
		else $error("result word changed while stalled");

	// With the output side free, the input side must never stall.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output was free");

	// A fresh result from an empty output stage comes from a word taken through the input stage.
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result word without a matching input word");

endmodule

bind text_cursor_glyph_layout tcgl_checker u_tcgl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (text_in.valid),
	.in_ready       (text_in.ready),
	.out_valid      (glyph_out.valid),
	.out_ready      (glyph_out.ready),
	.glyph_x        (glyph_out.glyph_x),
	.glyph_y        (glyph_out.glyph_y),
	.glyph_column   (glyph_out.glyph_column),
	.glyph_row      (glyph_out.glyph_row),
	.box_full_after (glyph_out.box_full_after)
);

`default_nettype wire

// ----- test/text_cursor_glyph_layout_tb.sv -----
`timescale 1ns / 1ps

module text_cursor_glyph_layout_tb;
	import tcgl_pkg::*;

	localparam int CELL_W_PX  = 8;
	localparam int CELL_H_PX  = 16;
	localparam int GLYPHS_ROW = 16;
	localparam int TAB_STOP   = 4;
	localparam int SETTLE     = 4;
	localparam int CYCLE_CAP  = 1000000;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic               full;
	} glyph_t;

	logic clk;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	tcgl_in_if  text_in ();
	tcgl_out_if glyph_out ();

	text_cursor_glyph_layout dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in),
		.glyph_out (glyph_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	box_cfg_t    box = '{BASE_X_RST, BASE_Y_RST, BOX_WIDTH_RST, BOX_HEIGHT_RST};
	int unsigned cur_x = 0;
	int unsigned cur_y = 0;
	bit          halted = 1'b0;
	glyph_t      pending_glyphs[$];

	int src_idle_pct = 0;
	int rcv_stall_pct = 0;
	int err_cnt = 0;
	int cycle_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int unsigned clip(input int unsigned v);
		return (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	task automatic line_feed();
		cur_x = box.base_x;
		cur_y = clip(cur_y + CELL_H_PX);
		if (cur_y > box.base_y + box.box_height)
			halted = 1'b1;
	endtask

	// Moves the cursor for one accepted word and queues the glyph it emits, if any.
	task automatic advance_cursor(input logic [CODE_W-1:0] code, input logic sot);
		int unsigned off;
		int unsigned n;
		int unsigned idx;
		glyph_t g;
		if (sot) begin
			cur_x = box.base_x;
			cur_y = box.base_y;
			halted = 1'b0;
		end
		if (halted)
			return;
		case (code)
			CHAR_CR: begin
				cur_x = box.base_x;
			end
			CHAR_LF: begin
				line_feed();
			end
			CHAR_TAB: begin
				off = (cur_x >= box.base_x) ? cur_x - box.base_x : 0;
				n = off / CELL_W_PX;
				n += TAB_STOP - n % TAB_STOP;
				cur_x = clip(box.base_x + n * CELL_W_PX);
				if (cur_x > box.base_x + box.box_width)
					line_feed();
			end
			default: begin
				idx = (code >= CODE_FIRST && code <= CODE_LAST) ? code - CODE_FIRST : 0;
				g.x = COORD_W'(cur_x);
				g.y = COORD_W'(cur_y);
				g.col = COL_W'(idx % GLYPHS_ROW);
				g.row = ROW_W'(idx / GLYPHS_ROW);
				cur_x = clip(cur_x + CELL_W_PX);
				if (cur_x + CELL_W_PX > box.base_x + box.box_width)
					line_feed();
				g.full = halted;
				pending_glyphs.push_back(g);
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s mismatch: expected %0d, got %0d", what, want, got);
	endtask

	always @(posedge clk) begin
		glyph_out.ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	always @(posedge clk) begin : check_glyphs
		glyph_t exp_g;
		if (arst_n && glyph_out.valid && glyph_out.ready) begin
			if (pending_glyphs.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected glyph word at x=%0d y=%0d",
						glyph_out.glyph_x, glyph_out.glyph_y);
			end else begin
				exp_g = pending_glyphs.pop_front();
				if (glyph_out.glyph_x !== exp_g.x)
					flag_mismatch("glyph_x", exp_g.x, glyph_out.glyph_x);
				if (glyph_out.glyph_y !== exp_g.y)
					flag_mismatch("glyph_y", exp_g.y, glyph_out.glyph_y);
				if (glyph_out.glyph_column !== exp_g.col)
					flag_mismatch("glyph_column", exp_g.col, glyph_out.glyph_column);
				if (glyph_out.glyph_row !== exp_g.row)
					flag_mismatch("glyph_row", exp_g.row, glyph_out.glyph_row);
				if (glyph_out.box_full_after !== exp_g.full)
					flag_mismatch("box_full_after", exp_g.full, glyph_out.box_full_after);
			end
		end
	end

	task automatic send_word(input logic [CODE_W-1:0] code, input logic sot);
		while ($urandom_range(99) < src_idle_pct) begin
			text_in.valid <= 1'b0;
			@(posedge clk);
		end
		text_in.valid <= 1'b1;
		text_in.char_code <= code;
		text_in.start_of_text <= sot;
		@(posedge clk);
		while (!text_in.ready)
			@(posedge clk);
		advance_cursor(code, sot);
	endtask

	task automatic drain();
		text_in.valid <= 1'b0;
		while (pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_box(input box_cfg_t b);
		cfg_we <= 1'b1;
		cfg_index <= REG_BASE_X;
		cfg_wdata <= b.base_x;
		@(posedge clk);
		cfg_index <= REG_BASE_Y;
		cfg_wdata <= b.base_y;
		@(posedge clk);
		cfg_index <= REG_BOX_WIDTH;
		cfg_wdata <= b.box_width;
		@(posedge clk);
		cfg_index <= REG_BOX_HEIGHT;
		cfg_wdata <= b.box_height;
		@(posedge clk);
		cfg_we <= 1'b0;
		box = b;
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return CODE_W'($urandom_range(CODE_LAST, CODE_FIRST));
		if (r < 81)
			return CHAR_LF;
		if (r < 86)
			return CHAR_TAB;
		if (r < 89)
			return CHAR_CR;
		if (r < 95)
			return CODE_W'($urandom_range(8'hFF, 8'h80));
		return CODE_W'($urandom_range(CODE_FIRST - 1, 0));
	endfunction

	function automatic box_cfg_t pick_box();
		box_cfg_t b;
		case ($urandom_range(4))
			0: b = '{BASE_X_RST, BASE_Y_RST, BOX_WIDTH_RST, BOX_HEIGHT_RST};
			1: b = '0;
			2: b = '1;
			3: begin
				b.base_x = CFG_W'($urandom_range(4095));
				b.base_y = CFG_W'($urandom_range(4095));
				b.box_width = CFG_W'($urandom_range(160));
				b.box_height = CFG_W'($urandom_range(120));
			end
			default: begin
				b.base_x = CFG_W'($urandom_range(4095));
				b.base_y = CFG_W'($urandom_range(4095));
				b.box_width = CFG_W'($urandom_range(4095));
				b.box_height = CFG_W'($urandom_range(4095));
			end
		endcase
		return b;
	endfunction

	// Most strings open with a start of text; a few run on from a stopped or
	// moved cursor, and a rare start lands in the middle of a string.
	task automatic run_text(input int src_pct, input int rcv_pct, input int n_words);
		int counted;
		int len;
		bit lead;
		src_idle_pct = src_pct;
		rcv_stall_pct = rcv_pct;
		for (int seg = 0; seg < 2; seg++) begin
			write_box(pick_box());
			counted = 0;
			while (counted < n_words / 2) begin
				len = $urandom_range(40, 1);
				lead = ($urandom_range(9) != 0);
				for (int k = 0; k < len; k++) begin
					send_word(pick_code(), (k == 0) ? lead : ($urandom_range(99) == 0));
					counted++;
				end
			end
			drain();
		end
	endtask

	task automatic test_directed();
		box_cfg_t b;
		send_word(8'h41, 1'b1);
		send_word(CODE_FIRST, 1'b0);
		send_word(CODE_LAST, 1'b0);
		send_word(CODE_FIRST - 1, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(CHAR_TAB, 1'b0);
		send_word(8'h21, 1'b0);
		send_word(CHAR_CR, 1'b0);
		send_word(8'h7E, 1'b0);
		send_word(CHAR_LF, 1'b0);
		send_word(8'h5A, 1'b0);
		drain();
		// The base moves right of the cursor without a new start of text.
		b = '{12'd64, 12'd0, BOX_WIDTH_RST, BOX_HEIGHT_RST};
		write_box(b);
		send_word(CHAR_TAB, 1'b0);
		send_word(8'h78, 1'b0);
		drain();
		// An empty box stops after the first glyph until the next start.
		write_box('0);
		send_word(8'h61, 1'b1);
		send_word(8'h62, 1'b0);
		send_word(CHAR_LF, 1'b0);
		send_word(8'h63, 1'b1);
		drain();
	endtask

	task automatic test_saturation();
		write_box('1);
		send_word(8'h41, 1'b1);
		for (int i = 0; i < 280; i++) begin
			if (i % 16 == 15)
				send_word(pick_code(), 1'b0);
			else if (i % 37 == 36)
				send_word(CHAR_TAB, 1'b0);
			else
				send_word(CHAR_LF, 1'b0);
		end
		send_word(CHAR_TAB, 1'b1);
		send_word(8'h7F, 1'b0);
		drain();
	endtask

	task automatic test_steady_stream();
		run_text(0, 0, 300);
	endtask

	task automatic test_sender_gaps();
		run_text(81, 0, 300);
	endtask

	task automatic test_receiver_stalls();
		run_text(0, 81, 300);
	endtask

	task automatic test_mixed_gaps();
		run_text(30, 30, 300);
	endtask

	initial begin
		arst_n <= 1'b0;
		text_in.valid <= 1'b0;
		text_in.char_code <= '0;
		text_in.start_of_text <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_steady_stream();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_gaps();
		drain();
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
